// ===== rtl/core/page_hotness_tracker_top_macros.svh =====
// ---------------------------------------------------------------------------
// Page hotness tracker assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet while in reset.
// ---------------------------------------------------------------------------
`ifndef PAGE_HOTNESS_TRACKER_TOP_MACROS_SVH
`define PAGE_HOTNESS_TRACKER_TOP_MACROS_SVH

// same-cycle implication
`define PHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pht_pkg.sv =====
// ---------------------------------------------------------------------------
// Page hotness tracker package
// Shared codes, defaults and the item passed from front to back.
// ---------------------------------------------------------------------------
package pht_pkg;

  localparam int PAGES_DEF      = 4096;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic [2:0] CMD_SAMPLE = 3'd0;
  localparam logic [2:0] CMD_ACK    = 3'd1;
  localparam logic [2:0] CMD_MAP    = 3'd2;
  localparam logic [2:0] CMD_REMOVE = 3'd3;
  localparam logic [2:0] CMD_COOL   = 3'd4;

  localparam logic [2:0] ST_NONE      = 3'd0;
  localparam logic [2:0] ST_ZERO_ADDR = 3'd1;
  localparam logic [2:0] ST_UNTRACKED = 3'd2;
  localparam logic [2:0] ST_UNMAPPED  = 3'd3;
  localparam logic [2:0] ST_COUNTED   = 3'd4;

  localparam logic [1:0] REQ_NONE = 2'd0;
  localparam logic [1:0] REQ_HOT  = 2'd1;
  localparam logic [1:0] REQ_COLD = 2'd2;

  localparam logic [1:0] EV_INVALID = 2'd3;

  localparam logic [1:0] CFG_WRITE_LIM = 2'd0;
  localparam logic [1:0] CFG_READ_LIM  = 2'd1;
  localparam logic [1:0] CFG_COOL_LIM  = 2'd2;
  localparam logic [1:0] CFG_MANAGED   = 2'd3;

  localparam logic [15:0] WRITE_LIM_RST = 16'd4;
  localparam logic [15:0] READ_LIM_RST  = 16'd8;
  localparam logic [15:0] COOL_LIM_RST  = 16'd18;
  localparam logic [12:0] MANAGED_RST   = 13'd4096;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [11:0] page;
    logic [1:0]  ev;
    logic        fv;
    logic [2:0]  status;
    logic        rmw;
  } item_t;

endpackage

// ===== rtl/core/pht_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module pht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/pht_front.sv =====
// ---------------------------------------------------------------------------
// Page hotness tracker front end
// Accept items, classify them and hold them in a two-entry queue.
// ---------------------------------------------------------------------------
module pht_front #(
  parameter int PAGES = pht_pkg::PAGES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2:0]      cmd,
  input  logic [11:0]     page,
  input  logic [1:0]      ev,
  input  logic            addr_nz,
  input  logic            fv,
  input  logic [12:0]     managed,
  input  logic            clearing,
  output logic            q_valid,
  input  logic            q_ready,
  output pht_pkg::item_t  q_item
);

  pht_pkg::item_t cls;
  pht_pkg::item_t slot_r [2];
  logic           wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           tracked, push, pop;

  assign tracked = (32'(page) < PAGES) && ({1'b0, page} < managed);

  // classify: memory access needed only for tracked page work
  always_comb begin
    cls        = '0;
    cls.cmd    = cmd;
    cls.page   = page;
    cls.ev     = ev;
    cls.fv     = fv;
    cls.status = pht_pkg::ST_NONE;
    cls.rmw    = 1'b0;
    unique case (cmd)
      pht_pkg::CMD_SAMPLE: begin
        if (ev == pht_pkg::EV_INVALID) begin
          cls.status = pht_pkg::ST_NONE;
        end else if (!addr_nz) begin
          cls.status = pht_pkg::ST_ZERO_ADDR;
        end else if (!tracked) begin
          cls.status = pht_pkg::ST_UNTRACKED;
        end else begin
          cls.status = pht_pkg::ST_COUNTED;
          cls.rmw    = 1'b1;
        end
      end
      pht_pkg::CMD_ACK, pht_pkg::CMD_MAP, pht_pkg::CMD_REMOVE: begin
        cls.rmw = tracked;
      end
      default: begin
        cls.rmw = 1'b0;
      end
    endcase
  end

  assign in_ready = !clearing && (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= cls;
    end
  end

endmodule

// ===== rtl/core/pht_back.sv =====
// ---------------------------------------------------------------------------
// Page hotness tracker back end
// Read-modify-write of the page table, global epoch and result register.
// ---------------------------------------------------------------------------
`include "page_hotness_tracker_top_macros.svh"

module pht_back #(
  parameter int PAGES      = pht_pkg::PAGES_DEF,
  parameter int COUNT_BITS = pht_pkg::COUNT_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  pht_pkg::item_t q_item,
  input  logic [15:0]    write_lim,
  input  logic [15:0]    read_lim,
  input  logic [15:0]    cool_lim,
  output logic           clearing,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     o_request,
  output logic [11:0]    o_page,
  output logic [2:0]     o_status,
  output logic           o_adv,
  output logic [31:0]    o_epoch,
  output logic           o_fast,
  output logic           o_slow
);

  localparam int AW  = $clog2(PAGES);
  localparam int CB  = COUNT_BITS;
  localparam int EW  = 3 * CB + 32 + 3;
  localparam int EPO = 3 * CB;
  localparam int FLO = 3 * CB + 32;
  localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;

  logic [2:0]     state_r, state_nxt;
  logic [AW-1:0]  clr_r, clr_nxt;
  pht_pkg::item_t it_r;
  logic [EW-1:0]  ent_r, ent_nxt;
  logic           wr_r, wr_nxt;
  logic [1:0]     req_r, req_nxt;
  logic [2:0]     st_r, st_nxt;
  logic [31:0]    diff_r, diff_nxt;
  logic [31:0]    g_r, g_nxt;
  logic [1:0]     cool_r, cool_nxt;

  logic           out_v_r, out_v_nxt;
  logic [1:0]     oreq_r;
  logic [11:0]    opg_r;
  logic [2:0]     ost_r;
  logic           oadv_r;

  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr;
  logic [EW-1:0]  ram_wdata, ram_rdata;

  logic [CB-1:0]  cnt_a [3];
  logic [CB-1:0]  ecnt_a [3];
  logic [CB-1:0]  shifted;
  logic [EW-1:0]  wb_ent;
  logic [2:0]     fl;
  logic           is_hot, adv, wb_go;

  pht_ram #(.WIDTH(EW), .DEPTH(PAGES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (AW'(q_item.page)),
    .rdata (ram_rdata)
  );

  assign clearing = (state_r == S_CLR);
  assign q_ready  = (state_r == S_IDLE);
  assign ram_re   = q_valid && q_ready && q_item.rmw;
  assign wb_go    = (state_r == S_WB) && (!out_v_r || out_ready);

  // update the read entry
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cnt_a[i] = ram_rdata[i*CB +: CB];
    end
    fl       = ram_rdata[FLO +: 3];
    ent_nxt  = ram_rdata;
    wr_nxt   = 1'b0;
    req_nxt  = pht_pkg::REQ_NONE;
    st_nxt   = it_r.status;
    diff_nxt = g_r - ram_rdata[EPO +: 32];
    is_hot   = 1'b0;
    unique case (it_r.cmd)
      pht_pkg::CMD_SAMPLE: begin
        if (!fl[2]) begin
          st_nxt = pht_pkg::ST_UNMAPPED;
        end else begin
          if (cnt_a[it_r.ev] != CNT_MAX) begin
            cnt_a[it_r.ev] = cnt_a[it_r.ev] + CB'(1);
          end
          is_hot = (32'(cnt_a[2]) >= 32'(write_lim)) ||
                   ((33'(cnt_a[0]) + 33'(cnt_a[1])) >= 33'(read_lim));
          if (is_hot) begin
            if (!fl[0] || !fl[1]) begin
              req_nxt = pht_pkg::REQ_HOT;
            end
          end else if (fl[0] || !fl[1]) begin
            req_nxt = pht_pkg::REQ_COLD;
          end
          if (req_nxt != pht_pkg::REQ_NONE) begin
            fl[1] = 1'b1;
          end
          wr_nxt = 1'b1;
        end
      end
      pht_pkg::CMD_ACK: begin
        fl[1] = 1'b0;
        if (fl[2]) begin
          fl[0] = it_r.fv;
        end
        wr_nxt = 1'b1;
      end
      pht_pkg::CMD_MAP: begin
        fl[2]  = 1'b1;
        wr_nxt = 1'b1;
      end
      pht_pkg::CMD_REMOVE: begin
        fl[2] = 1'b0;
        fl[0] = 1'b0;
        for (int i = 0; i < 3; i++) begin
          cnt_a[i] = '0;
        end
        wr_nxt = 1'b1;
      end
      default: begin
        wr_nxt = 1'b0;
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      ent_nxt[i*CB +: CB] = cnt_a[i];
    end
    ent_nxt[FLO +: 3] = fl;
  end

  // decay the sampled counter and stamp the epoch
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ecnt_a[i] = ent_r[i*CB +: CB];
    end
    shifted = (diff_r >= 32'(CB)) ? '0 : (ecnt_a[it_r.ev] >> diff_r);
    wb_ent  = ent_r;
    adv     = 1'b0;
    if (it_r.cmd == pht_pkg::CMD_SAMPLE && st_r == pht_pkg::ST_COUNTED) begin
      wb_ent[it_r.ev*CB +: CB] = shifted;
      wb_ent[EPO +: 32]        = g_r;
      adv = 32'(shifted) > 32'(cool_lim);
    end
  end

  always_comb begin
    g_nxt    = g_r;
    cool_nxt = cool_r;
    if (wb_go) begin
      if (adv) begin
        g_nxt    = g_r + 32'd1;
        cool_nxt = 2'b11;
      end else if (it_r.cmd == pht_pkg::CMD_COOL) begin
        cool_nxt = it_r.fv ? (cool_r & 2'b01) : (cool_r & 2'b10);
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(it_r.page);
    ram_wdata = wb_ent;
    clr_nxt   = clr_r;
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(PAGES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          state_nxt = q_item.rmw ? S_CALC : S_WB;
        end
      end
      S_CALC: begin
        state_nxt = S_WB;
      end
      S_WB: begin
        if (wb_go) begin
          ram_we    = wr_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_v_nxt = wb_go ? 1'b1 : (out_ready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      g_r     <= '0;
      cool_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      g_r     <= g_nxt;
      cool_r  <= cool_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && q_valid) begin
      it_r   <= q_item;
      st_r   <= q_item.status;
      req_r  <= pht_pkg::REQ_NONE;
      wr_r   <= 1'b0;
      diff_r <= '0;
      ent_r  <= '0;
    end
    if (state_r == S_CALC) begin
      ent_r  <= ent_nxt;
      wr_r   <= wr_nxt;
      req_r  <= req_nxt;
      st_r   <= st_nxt;
      diff_r <= diff_nxt;
    end
    if (wb_go) begin
      oreq_r <= req_r;
      opg_r  <= (req_r != pht_pkg::REQ_NONE) ? it_r.page : 12'd0;
      ost_r  <= st_r;
      oadv_r <= adv;
    end
  end

  assign out_valid = out_v_r;
  assign o_request = oreq_r;
  assign o_page    = opg_r;
  assign o_status  = ost_r;
  assign o_adv     = oadv_r;
  assign o_epoch   = g_r;
  assign o_fast    = cool_r[0];
  assign o_slow    = cool_r[1];

  `PHT_ASSERT_NOW(a_no_out_clear, state_r == S_CLR, !out_v_r, "result during clearing")
  `PHT_ASSERT_NOW(a_we_phase, ram_we, state_r == S_WB || state_r == S_CLR,
    "table write outside write-back")
  `PHT_ASSERT_NEXT(a_epoch_step, 1'b1,
    !$past(rst_n) || g_r == $past(g_r) || g_r == $past(g_r) + 32'd1,
    "epoch moved by more than one")
  `PHT_ASSERT_NOW(a_pop_idle, q_valid && q_ready, state_r == S_IDLE,
    "queue popped while busy")

endmodule

// ===== rtl/core/page_hotness_tracker_top.sv =====
// ---------------------------------------------------------------------------
// Page hotness tracker
// Per-page access sampling table with hot/cold requests and epoch decay.
// ---------------------------------------------------------------------------
//  channel  | direction | contents
//  in_*     | in        | tuser: command; tdata: page, event type, addr nonzero, flag
//  out_*    | out       | tdata: request, page, status, advanced, epoch, cool flags
//  cfg_*    | in        | write enable, register index, 16-bit data
//
//  After reset the page table is cleared one entry a cycle, all PAGES entries
//  (4096 by default), with in_tready low; configuration writes still land.
//  A table item passes the back-end states idle (table read), calc (update)
//  and write back; an item without table work goes from idle to write back.
//  A two-entry queue lets input accept while a result waits on out_tready.
// ---------------------------------------------------------------------------
module page_hotness_tracker_top #(
  parameter int PAGES      = pht_pkg::PAGES_DEF,
  parameter int COUNT_BITS = pht_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [11:0] page_index, [13:12] event_type, [14] address_nonzero, [15] flag_value
  input  logic [15:0] in_tdata,
  // [2:0] command
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] request, [13:2] request_page, [16:14] sample_status,
  // [17] epoch_advanced, [49:18] epoch_now, [50] fast_cool_pending,
  // [51] slow_cool_pending, [55:52] zero
  output logic [55:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);

  logic [15:0]    write_lim_r, read_lim_r, cool_lim_r;
  logic [12:0]    managed_r;
  logic           clearing, q_valid, q_ready;
  pht_pkg::item_t q_item;

  logic [1:0]  o_request;
  logic [11:0] o_page;
  logic [2:0]  o_status;
  logic        o_adv, o_fast, o_slow;
  logic [31:0] o_epoch;

  // hold the configuration registers; reset to their documented defaults
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_lim_r <= pht_pkg::WRITE_LIM_RST;
      read_lim_r  <= pht_pkg::READ_LIM_RST;
      cool_lim_r  <= pht_pkg::COOL_LIM_RST;
      managed_r   <= pht_pkg::MANAGED_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        pht_pkg::CFG_WRITE_LIM: write_lim_r <= cfg_wdata;
        pht_pkg::CFG_READ_LIM:  read_lim_r  <= cfg_wdata;
        pht_pkg::CFG_COOL_LIM:  cool_lim_r  <= cfg_wdata;
        pht_pkg::CFG_MANAGED:   managed_r   <= cfg_wdata[12:0];
        default:                managed_r   <= managed_r;
      endcase
    end
  end

  // front: accept and classify, queue towards the table
  pht_front #(.PAGES(PAGES)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .cmd      (in_tuser),
    .page     (in_tdata[11:0]),
    .ev       (in_tdata[13:12]),
    .addr_nz  (in_tdata[14]),
    .fv       (in_tdata[15]),
    .managed  (managed_r),
    .clearing (clearing),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  // back: table update, epoch and result register
  pht_back #(.PAGES(PAGES), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .write_lim (write_lim_r),
    .read_lim  (read_lim_r),
    .cool_lim  (cool_lim_r),
    .clearing  (clearing),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .o_request (o_request),
    .o_page    (o_page),
    .o_status  (o_status),
    .o_adv     (o_adv),
    .o_epoch   (o_epoch),
    .o_fast    (o_fast),
    .o_slow    (o_slow)
  );

  assign out_tdata = {4'd0, o_slow, o_fast, o_epoch, o_adv, o_status, o_page, o_request};

endmodule
